FILE: hw/rtl/hmwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmwc_pkg: shared types and constants of the host mask width checker
// Holds the verdict codes, the character codes the scanner looks for and the
// record of running scan state passed between the tracker and the judge.
// ----------------------------------------------------------------------------
package hmwc_pkg;

  // Verdict codes.
  localparam logic [1:0] VERDICT_APPROVED    = 2'd0;
  localparam logic [1:0] VERDICT_OVERRIDABLE = 2'd1;
  localparam logic [1:0] VERDICT_REJECTED    = 2'd2;

  // Characters with a meaning of their own.
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_QUERY = 8'h3F;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Saturation limits and thresholds.
  localparam logic [2:0] DOT_MAX       = 3'd4;
  localparam logic [2:0] DOT_IP        = 3'd3;
  localparam logic [2:0] DOT_HOST_MIN  = 3'd2;
  localparam logic [5:0] PREFIX_MAX    = 6'd32;
  localparam logic [5:0] PREFIX_STEP   = 6'd8;
  localparam logic [5:0] SLASH_SAT     = 6'd33;
  localparam logic [5:0] IP_PREFIX_MIN = 6'd16;

  // Running state of one mask scan.
  typedef struct packed {
    logic       wild_in_last_field;
    logic       wild_in_prev_field;
    logic       any_wildcard;
    logic       looks_like_ip;
    logic [2:0] dot_count;
    logic [5:0] prefix_bits;
    logic       after_slash;
    logic [5:0] slash_value;
    logic       slash_bad;
    logic       slash_ready;
  } scan_state_t;

  localparam scan_state_t SCAN_STATE_INIT = '{
    wild_in_last_field: 1'b0,
    wild_in_prev_field: 1'b0,
    any_wildcard:       1'b0,
    looks_like_ip:      1'b1,
    dot_count:          3'd0,
    prefix_bits:        6'd0,
    after_slash:        1'b0,
    slash_value:        6'd0,
    slash_bad:          1'b0,
    slash_ready:        1'b0
  };

endpackage

FILE: hw/rtl/hmwc_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmwc_track: running scan state of the mask
// Folds one character into the scan state and holds that state between
// characters. The updated state is also given out for the verdict logic.
// ----------------------------------------------------------------------------
module hmwc_track (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,       // a character request advances
  input  logic [7:0]           char_code,
  input  logic                 has_char,
  input  logic                 last,
  output hmwc_pkg::scan_state_t state_next
);

  hmwc_pkg::scan_state_t state;

  // Fold one character into the state.
  function automatic hmwc_pkg::scan_state_t take_char(input hmwc_pkg::scan_state_t s,
                                                      input logic [7:0] c);
    hmwc_pkg::scan_state_t r;
    logic                  digit;
    logic [8:0]            value;
    logic [6:0]            prefix;
    r      = s;
    digit  = (c >= hmwc_pkg::CHAR_ZERO) && (c <= hmwc_pkg::CHAR_NINE);
    value  = 9'(s.slash_value) * 9'd10 + 9'(c - hmwc_pkg::CHAR_ZERO);
    prefix = 7'(s.prefix_bits) + 7'(hmwc_pkg::PREFIX_STEP);
    if (s.after_slash) begin
      if (digit) begin
        r.slash_value = (value > 9'(hmwc_pkg::SLASH_SAT)) ? hmwc_pkg::SLASH_SAT
                                                          : value[5:0];
        r.slash_ready = 1'b1;
      end else begin
        r.slash_bad = 1'b1;
      end
    end else if (c == hmwc_pkg::CHAR_DOT) begin
      r.wild_in_prev_field = s.wild_in_last_field;
      r.wild_in_last_field = 1'b0;
      if (s.dot_count < hmwc_pkg::DOT_MAX) begin
        r.dot_count = s.dot_count + 3'd1;
      end
      if (s.looks_like_ip && !s.any_wildcard) begin
        r.prefix_bits = (prefix > 7'(hmwc_pkg::PREFIX_MAX)) ? hmwc_pkg::PREFIX_MAX
                                                            : prefix[5:0];
      end
    end else if (c == hmwc_pkg::CHAR_STAR || c == hmwc_pkg::CHAR_QUERY) begin
      r.wild_in_last_field = 1'b1;
      r.any_wildcard       = 1'b1;
    end else if (c == hmwc_pkg::CHAR_SLASH) begin
      r.after_slash = 1'b1;
    end else if (!digit) begin
      r.looks_like_ip = 1'b0;
      r.prefix_bits   = 6'd0;
    end
    return r;
  endfunction

  // Next state with the current character taken in.
  always_comb begin
    state_next = has_char ? take_char(state, char_code) : state;
  end

  // The state returns to its initial values once a mask has ended.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hmwc_pkg::SCAN_STATE_INIT;
    end else if (step) begin
      state <= last ? hmwc_pkg::SCAN_STATE_INIT : state_next;
    end
  end

endmodule

FILE: hw/rtl/hmwc_judge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmwc_judge: verdict on a finished mask
// Turns the final scan state into approved, overridable or rejected.
// ----------------------------------------------------------------------------
module hmwc_judge (
  input  hmwc_pkg::scan_state_t state,
  output logic [1:0]            verdict
);

  logic       wilds;
  logic       ip;
  logic       halt;
  logic       reject;
  logic [5:0] value;
  logic [5:0] bits;

  always_comb begin
    wilds  = state.any_wildcard;
    ip     = state.looks_like_ip;
    halt   = 1'b0;
    reject = 1'b0;
    bits   = state.prefix_bits;
    value  = state.slash_ready ? state.slash_value : 6'd0;

    // An explicit bit count is only allowed on a clean dotted quad.
    if (state.after_slash) begin
      if (state.slash_bad || state.dot_count != hmwc_pkg::DOT_IP ||
          value > hmwc_pkg::PREFIX_MAX || !ip || wilds) begin
        reject = 1'b1;
      end
      bits = value;
      if (value < hmwc_pkg::PREFIX_MAX) begin
        wilds = 1'b1;
      end
      halt = 1'b1;
    end

    // Too many dots, or too few without wildcards, is not an address.
    if (state.dot_count > hmwc_pkg::DOT_IP ||
        (!wilds && state.dot_count < hmwc_pkg::DOT_IP)) begin
      ip   = 1'b0;
      bits = 6'd0;
    end

    // The last octet counts when no slash gave the width.
    if (ip && !wilds && !halt) begin
      bits = bits + hmwc_pkg::PREFIX_STEP;
    end

    // Wildcarded masks must keep enough fixed part.
    if (wilds &&
        ((!ip && (state.dot_count < hmwc_pkg::DOT_HOST_MIN ||
                  state.wild_in_last_field || state.wild_in_prev_field)) ||
         (ip && bits < hmwc_pkg::IP_PREFIX_MIN))) begin
      reject = 1'b1;
    end

    if (reject) begin
      verdict = hmwc_pkg::VERDICT_REJECTED;
    end else if (wilds) begin
      verdict = hmwc_pkg::VERDICT_OVERRIDABLE;
    end else begin
      verdict = hmwc_pkg::VERDICT_APPROVED;
    end
  end

endmodule

FILE: hw/rtl/host_mask_width_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// host_mask_width_checker: host mask verdict over a character stream
// Scans a host mask one character per request and rates it on the last one.
// ----------------------------------------------------------------------------
// The block takes one mask character per clock cycle and gives one verdict
// request for each request marked tlast: 0 approved, 1 overridable because
// wildcarded, 2 rejected as malformed or too wide. A character passes an input
// register, is folded into the running scan state, and on the last character
// the verdict is formed in the same cycle and held in an output register. The
// throughput is one character per cycle; the input stalls only while a
// finished verdict waits in the output register and another last character
// is ready to follow it. tuser low marks a request with no character, which
// lets an empty mask be ended. A '/' must be followed by decimal digits only.
// ----------------------------------------------------------------------------
module host_mask_width_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_code
  input  logic       s_axis_tuser,   // [0] has_char
  input  logic       s_axis_tlast,   // last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [1:0] verdict, [7:2] zero
);

  logic                  in_valid;
  logic [7:0]            in_char;
  logic                  in_has;
  logic                  in_last;
  logic                  out_free;
  logic                  step;
  logic [1:0]            verdict;
  logic [1:0]            verdict_calc;
  hmwc_pkg::scan_state_t state_next;

  // The held character moves on unless its verdict has nowhere to go.
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign step          = in_valid && (!in_last || out_free);
  assign s_axis_tready = !rst && (!in_valid || step);

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char <= s_axis_tdata;
      in_has  <= s_axis_tuser;
      in_last <= s_axis_tlast;
    end
  end

  hmwc_track u_track (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .char_code  (in_char),
    .has_char   (in_has),
    .last       (in_last),
    .state_next (state_next)
  );

  hmwc_judge u_judge (
    .state   (state_next),
    .verdict (verdict_calc)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step && in_last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last) begin
      verdict <= verdict_calc;
    end
  end

  assign m_axis_tdata = {6'd0, verdict};

endmodule

FILE: hw/rtl/hmwc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmwc_checker: port-level checks of the host mask width checker
// Watches the stream ports for verdict codes, stall behavior and readiness.
// ----------------------------------------------------------------------------
module hmwc_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // Only the three defined verdicts ever leave the block.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[1:0] != hmwc_pkg::VERDICT_REJECTED + 2'd1)
    else $error("undefined verdict code");

  // The padding above the verdict stays zero.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[7:2] == 6'd0)
    else $error("verdict padding not zero");

  // A stalled verdict holds.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled verdict changed");

  // No verdict is pending right after reset.
  assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_axis_tvalid)
    else $error("verdict present after reset");

  // With the output empty the input never stalls.
  assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind host_mask_width_checker hmwc_checker u_hmwc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
